// File: hw/rtl/pts_pkg.sv
`default_nettype none
package pts_pkg;

  typedef struct packed {
    logic [2:0] func;
    logic [4:0] task_id;
    logic [1:0] priority_req;
    logic [2:0] tty;
    logic       foreground;
    logic       atomic_flag;
  } req_t;

  typedef struct packed {
    logic [4:0] running_now;
    logic [4:0] result_task;
    logic       status;
  } rsp_t;

  localparam logic [2:0] FN_SCHEDULE  = 3'd0;
  localparam logic [2:0] FN_CREATE    = 3'd1;
  localparam logic [2:0] FN_SUSPEND   = 3'd2;
  localparam logic [2:0] FN_RESUME    = 3'd3;
  localparam logic [2:0] FN_TERMINATE = 3'd4;
  localparam logic [2:0] FN_EXIT      = 3'd5;
  localparam logic [2:0] FN_RECLAIM   = 3'd6;
  localparam logic [2:0] FN_ATOMIC    = 3'd7;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_SUSP  = 2'd2;
  localparam logic [1:0] ST_TERM  = 2'd3;

  localparam logic [4:0] PROT_RESET = 5'd1;

endpackage
`default_nettype wire

// File: hw/rtl/pts_task_mem.sv
`default_nettype none
module pts_task_mem #(
  parameter int DEPTH = 16,
  parameter int IDW   = 5,
  parameter int EW    = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [EW-1:0]            rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [EW-1:0]            wr_data,
  input  wire logic [EW-1:0]            wr_mask
);
  localparam int AW = $clog2(DEPTH);

  logic [EW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [EW-1:0]    wr_init;

  // an entry never written reads as its place in the initial free chain
  function automatic logic [EW-1:0] rst_word(logic [AW-1:0] a);
    logic [IDW-1:0] nxt;
    logic [IDW-1:0] prv;
    prv = IDW'(a);
    if (int'(a) < DEPTH - 1) nxt = IDW'(a) + IDW'(2);
    else nxt = '0;
    return EW'({nxt, prv});
  endfunction

  assign wr_init = rst_word(wr_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // bit-enable write; the first write of an entry fills the unmasked bits from the chain
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < EW; b++) begin
        if (wr_mask[b] || !vld[wr_addr]) begin
          mem[wr_addr][b] <= wr_mask[b] ? wr_data[b] : wr_init[b];
        end
      end
    end
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : rst_word(rd_addr);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/priority_task_scheduler.sv
// one request in flight, next one taken the cycle after its response registers; a table
// read is used in the state after issue; an unlink writes in S_REM0-2, a link in S_APP0-1
// rst is synchronous: all tasks free on one chain, queues empty, no task running,
// protected task 1; the table needs no clearing pass, per-entry valid bits cover it
`default_nettype none
module priority_task_scheduler #(
  parameter int MAX_TASKS       = 16,
  parameter int PRIORITY_LEVELS = 4,
  parameter int TERMINALS       = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_ready,
  input  wire pts_pkg::req_t req,
  output      logic          rsp_valid,
  input  wire logic          rsp_ready,
  output      pts_pkg::rsp_t rsp,
  input  wire logic          cfg_valid,
  output      logic          cfg_ready,
  input  wire logic [4:0]    cfg_data
);
  import pts_pkg::*;

  localparam int IDW_RAW = $clog2(MAX_TASKS + 1);
  localparam int IDW     = (IDW_RAW > 5) ? IDW_RAW : 5;
  localparam int AW      = $clog2(MAX_TASKS);
  localparam int PW      = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int TW      = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int QN      = PRIORITY_LEVELS + 3;
  localparam int QW      = $clog2(QN);
  localparam int Q_SUSP  = PRIORITY_LEVELS;
  localparam int Q_TERM  = PRIORITY_LEVELS + 1;
  localparam int Q_FREE  = PRIORITY_LEVELS + 2;

  typedef struct packed {
    logic [1:0]     status;
    logic [PW-1:0]  prio;
    logic [IDW-1:0] parent;
    logic [TW-1:0]  term;
    logic           fg;
    logic           atomic;
    logic [IDW-1:0] next;
    logic [IDW-1:0] prev;
  } ent_t;

  localparam int EW = $bits(ent_t);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_SCH0, S_SCH1, S_PICK, S_CAP, S_REM0, S_REM1, S_REM2,
    S_APP0, S_APP1, S_CRE2, S_SR1, S_MOV0, S_MOV1, S_TRM1, S_TRM2, S_HB0,
    S_HB1, S_EXT1, S_RCL2, S_CLRA, S_DONE
  } state_t;

  state_t         st;
  state_t         ret;
  state_t         mret;
  req_t           op;
  logic [IDW-1:0] sid;
  logic [QW-1:0]  sq;
  ent_t           ent;
  logic [1:0]     mst;
  logic [IDW-1:0] run;
  logic [IDW-1:0] result;
  logic           fail;
  logic [4:0]     prot;
  logic [IDW-1:0] qh [QN];
  logic [IDW-1:0] qt [QN];
  logic [IDW-1:0] tfg [TERMINALS];

  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [EW-1:0]  rd_word;
  ent_t           rd_ent;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  ent_t           wdata;
  ent_t           wmask;

  logic           pick_found;
  logic [QW-1:0]  psel;
  logic [IDW-1:0] tid;
  logic [PW-1:0]  prio_sat;
  logic           tty_bad;
  logic [TW-1:0]  tty_idx;

  function automatic logic id_ok(logic [IDW-1:0] v);
    return (v != '0) && (int'(v) <= MAX_TASKS);
  endfunction

  function automatic logic [AW-1:0] id2a(logic [IDW-1:0] v);
    logic [IDW-1:0] t;
    t = v - IDW'(1);
    return t[AW-1:0];
  endfunction

  function automatic logic [QW-1:0] q_of(logic [1:0] s, logic [PW-1:0] pr);
    case (s)
      ST_READY: return QW'(pr);
      ST_SUSP:  return QW'(Q_SUSP);
      ST_TERM:  return QW'(Q_TERM);
      default:  return QW'(Q_FREE);
    endcase
  endfunction

  function automatic logic term_ok(logic [TW-1:0] t);
    return int'(t) < TERMINALS;
  endfunction

  assign rd_ent    = rd_word;
  assign req_ready = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign tid       = IDW'(op.task_id);
  assign tty_bad   = (op.tty == 3'd0) || (int'(op.tty) > TERMINALS);
  assign tty_idx   = TW'(op.tty - 3'd1);

  always_comb begin
    if (int'(op.priority_req) >= PRIORITY_LEVELS) prio_sat = PW'(PRIORITY_LEVELS - 1);
    else prio_sat = PW'(op.priority_req);
  end

  // lowest-numbered non-empty ready queue
  always_comb begin
    pick_found = 1'b0;
    psel       = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (id_ok(qh[i])) begin
        pick_found = 1'b1;
        psel       = QW'(i);
      end
    end
  end

  pts_task_mem #(
    .DEPTH(MAX_TASKS),
    .IDW  (IDW),
    .EW   (EW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_word),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wdata),
    .wr_mask(wmask)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = id2a(sid);
    wr_en   = 1'b0;
    wr_addr = id2a(sid);
    wdata   = '0;
    wmask   = '0;
    case (st)
      S_DISP: begin
        unique case (op.func)
          FN_CREATE: begin
            rd_en   = 1'b1;
            rd_addr = id2a(qh[Q_FREE]);
          end
          FN_SUSPEND, FN_RESUME, FN_TERMINATE: begin
            rd_en   = 1'b1;
            rd_addr = id2a(tid);
          end
          FN_EXIT: begin
            if (id_ok(run)) begin
              rd_en        = 1'b1;
              rd_addr      = id2a(run);
              wr_en        = 1'b1;
              wr_addr      = id2a(run);
              wdata.status = ST_TERM;
              wmask.status = '1;
            end
          end
          FN_RECLAIM: begin
            rd_en   = 1'b1;
            rd_addr = id2a(qh[Q_TERM]);
          end
          FN_ATOMIC: begin
            if (id_ok(run)) begin
              wr_en        = 1'b1;
              wr_addr      = id2a(run);
              wdata.atomic = op.atomic_flag;
              wmask.atomic = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SCH0: begin
        rd_en   = 1'b1;
        rd_addr = id2a(run);
      end
      S_PICK: begin
        rd_en   = 1'b1;
        rd_addr = id2a(qh[psel]);
      end
      S_REM0: begin
        if (id_ok(ent.prev)) begin
          wr_en      = 1'b1;
          wr_addr    = id2a(ent.prev);
          wdata.next = ent.next;
          wmask.next = '1;
        end
      end
      S_REM1: begin
        if (id_ok(ent.next)) begin
          wr_en      = 1'b1;
          wr_addr    = id2a(ent.next);
          wdata.prev = ent.prev;
          wmask.prev = '1;
        end
      end
      S_REM2: begin
        wr_en      = 1'b1;
        wmask.next = '1;
        wmask.prev = '1;
      end
      S_APP0: begin
        wr_en      = 1'b1;
        wdata.prev = qt[sq];
        wmask.next = '1;
        wmask.prev = '1;
      end
      S_APP1: begin
        if (id_ok(qt[sq])) begin
          wr_en      = 1'b1;
          wr_addr    = id2a(qt[sq]);
          wdata.next = sid;
          wmask.next = '1;
        end
      end
      S_CRE2: begin
        wr_en        = 1'b1;
        wdata.status = ST_READY;
        wdata.prio   = prio_sat;
        wdata.parent = run;
        wdata.term   = tty_idx;
        wdata.fg     = op.foreground;
        wmask.status = '1;
        wmask.prio   = '1;
        wmask.parent = '1;
        wmask.term   = '1;
        wmask.fg     = 1'b1;
        wmask.atomic = 1'b1;
      end
      S_MOV1: begin
        wr_en        = 1'b1;
        wdata.status = mst;
        wmask.status = '1;
      end
      S_HB0: begin
        rd_en   = 1'b1;
        rd_addr = id2a(ent.parent);
      end
      S_RCL2: begin
        wr_en        = 1'b1;
        wmask.status = '1;
        wmask.prio   = '1;
        wmask.parent = '1;
        wmask.term   = '1;
        wmask.fg     = 1'b1;
        wmask.atomic = 1'b1;
      end
      S_CLRA: begin
        if (id_ok(run)) begin
          wr_en        = 1'b1;
          wr_addr      = id2a(run);
          wmask.atomic = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      ret       <= S_IDLE;
      mret      <= S_IDLE;
      run       <= '0;
      prot      <= PROT_RESET;
      rsp_valid <= 1'b0;
      for (int i = 0; i < QN; i++) begin
        qh[i] <= '0;
        qt[i] <= '0;
      end
      qh[Q_FREE] <= IDW'(1);
      qt[Q_FREE] <= IDW'(MAX_TASKS);
      for (int i = 0; i < TERMINALS; i++) tfg[i] <= '0;
    end else begin
      if (cfg_valid) prot <= cfg_data;
      if (rsp_valid && rsp_ready && st != S_DONE) rsp_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (req_valid) begin
            op     <= req;
            fail   <= 1'b0;
            result <= '0;
            st     <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (op.func)
            FN_SCHEDULE: st <= S_SCH0;
            FN_CREATE: begin
              if (tty_bad || !id_ok(qh[Q_FREE])) begin
                fail <= 1'b1;
                st   <= S_DONE;
              end else begin
                sid <= qh[Q_FREE];
                sq  <= QW'(Q_FREE);
                ret <= S_CRE2;
                st  <= S_CAP;
              end
            end
            FN_SUSPEND, FN_RESUME: begin
              if (!id_ok(tid)) begin
                fail <= 1'b1;
                st   <= S_CLRA;
              end else begin
                sid <= tid;
                st  <= S_SR1;
              end
            end
            FN_TERMINATE: begin
              if (!id_ok(tid) || op.task_id == prot) begin
                fail <= 1'b1;
                st   <= S_CLRA;
              end else begin
                sid <= tid;
                st  <= S_TRM1;
              end
            end
            FN_EXIT: begin
              if (!id_ok(run)) begin
                fail <= 1'b1;
                st   <= S_DONE;
              end else begin
                sid <= run;
                st  <= S_EXT1;
              end
            end
            FN_RECLAIM: begin
              if (id_ok(qh[Q_TERM])) begin
                sid <= qh[Q_TERM];
                sq  <= QW'(Q_TERM);
                ret <= S_RCL2;
                st  <= S_CAP;
              end else begin
                st <= S_DONE;
              end
            end
            FN_ATOMIC: st <= S_DONE;
            default: st <= S_DONE;
          endcase
        end
        S_SCH0: st <= id_ok(run) ? S_SCH1 : S_PICK;
        S_SCH1: begin
          ent <= rd_ent;
          if (rd_ent.atomic) begin
            st <= S_DONE;
          end else begin
            sid <= run;
            sq  <= q_of(rd_ent.status, rd_ent.prio);
            ret <= S_PICK;
            st  <= S_APP0;
          end
        end
        S_PICK: begin
          if (pick_found) begin
            run <= qh[psel];
            sid <= qh[psel];
            sq  <= psel;
            ret <= S_DONE;
            st  <= S_CAP;
          end else begin
            run <= '0;
            st  <= S_DONE;
          end
        end
        S_CAP: begin
          ent <= rd_ent;
          st  <= S_REM0;
        end
        S_REM0: begin
          if (!id_ok(ent.prev)) qh[sq] <= ent.next;
          st <= S_REM1;
        end
        S_REM1: begin
          if (!id_ok(ent.next)) qt[sq] <= ent.prev;
          st <= S_REM2;
        end
        S_REM2: st <= ret;
        S_APP0: st <= S_APP1;
        S_APP1: begin
          if (!id_ok(qt[sq])) qh[sq] <= sid;
          qt[sq] <= sid;
          st     <= ret;
        end
        S_CRE2: begin
          result <= sid;
          if (op.foreground) tfg[tty_idx] <= sid;
          sq  <= QW'(prio_sat);
          ret <= S_DONE;
          st  <= S_APP0;
        end
        S_SR1: begin
          ent <= rd_ent;
          if (rd_ent.status == ST_EMPTY || rd_ent.status == ST_TERM) begin
            fail <= 1'b1;
            st   <= S_CLRA;
          end else if (op.func == FN_SUSPEND) begin
            if (rd_ent.status == ST_READY) begin
              mst  <= ST_SUSP;
              mret <= S_CLRA;
              st   <= S_MOV0;
            end else begin
              st <= S_CLRA;
            end
          end else begin
            if (rd_ent.status == ST_SUSP) begin
              mst  <= ST_READY;
              mret <= S_CLRA;
              st   <= S_MOV0;
            end else begin
              st <= S_CLRA;
            end
          end
        end
        // the running task sits in no queue; only its status changes
        S_MOV0: begin
          if (sid != run) begin
            sq  <= q_of(ent.status, ent.prio);
            ret <= S_MOV1;
            st  <= S_REM0;
          end else begin
            st <= S_MOV1;
          end
        end
        S_MOV1: begin
          if (sid != run) begin
            sq  <= q_of(mst, ent.prio);
            ret <= mret;
            st  <= S_APP0;
          end else begin
            st <= mret;
          end
        end
        S_TRM1: begin
          ent <= rd_ent;
          if (rd_ent.status == ST_EMPTY || rd_ent.status == ST_TERM) begin
            fail <= 1'b1;
            st   <= S_CLRA;
          end else begin
            mst  <= ST_TERM;
            mret <= S_TRM2;
            st   <= S_MOV0;
          end
        end
        S_TRM2: begin
          if (term_ok(ent.term) && tfg[ent.term] == sid) st <= S_HB0;
          else st <= S_CLRA;
        end
        // terminal goes back to the parent, which resumes if suspended
        S_HB0: begin
          if (term_ok(ent.term)) tfg[ent.term] <= ent.parent;
          if (id_ok(ent.parent)) begin
            sid <= ent.parent;
            st  <= S_HB1;
          end else begin
            st <= S_CLRA;
          end
        end
        S_HB1: begin
          ent <= rd_ent;
          if (rd_ent.status == ST_SUSP) begin
            mst  <= ST_READY;
            mret <= S_CLRA;
            st   <= S_MOV0;
          end else begin
            st <= S_CLRA;
          end
        end
        S_EXT1: begin
          ent <= rd_ent;
          st  <= rd_ent.fg ? S_HB0 : S_CLRA;
        end
        S_RCL2: begin
          result <= sid;
          sq     <= QW'(Q_FREE);
          ret    <= S_DONE;
          st     <= S_APP0;
        end
        S_CLRA: st <= (op.func == FN_EXIT) ? S_SCH0 : S_DONE;
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.running_now <= run[4:0];
            rsp.result_task <= result[4:0];
            rsp.status      <= fail;
            rsp_valid       <= 1'b1;
            st              <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pts_checker.sv
`default_nettype none
module pts_checker #(
  parameter int MAX_TASKS = 16
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire pts_pkg::rsp_t rsp
);
  import pts_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  a_fail_no_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.result_task == 5'd0)
    else $error("failed request reports a task");

  a_result_not_running: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_task != 5'd0 |-> rsp.result_task != rsp.running_now &&
      int'(rsp.result_task) <= MAX_TASKS)
    else $error("created or reclaimed task is running or out of range");

endmodule

bind priority_task_scheduler pts_checker #(.MAX_TASKS(MAX_TASKS)) u_pts_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);
`default_nettype wire
